[rtl/core/spsl_pkg.sv]
// Shared types and constants of the servo pulse slew limiter.
`timescale 1ns / 1ps

package spsl_pkg;

  localparam int unsigned POS_W  = 11;
  localparam int unsigned STEP_W = 13;
  localparam int unsigned DUTY_W = 10;

  localparam logic [POS_W-1:0] MIN_US = POS_W'(1000);
  localparam logic [POS_W-1:0] MAX_US = POS_W'(2000);

  // floor(p * 8191 / 20000) = floor(floor(p * 8191 / 32) / 625)
  localparam int unsigned PROD_W      = POS_W + 13;
  localparam int unsigned QUOT_W      = PROD_W - 5;
  localparam int unsigned RECIP_SHIFT = 28;
  localparam logic [QUOT_W-1:0] RECIP_625 = QUOT_W'(429497);

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_TICK = 2'd2
  } command_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] setpoint_us;
    logic [11:0] speed_q8_4;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] position_us;
    logic             moving;
    logic             reached;
  } ramp_t;

endpackage

[rtl/core/spsl_if.sv]
// Valid/ready channel interfaces for command beats and result beats.
`timescale 1ns / 1ps

interface spsl_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] setpoint_us;
  logic [11:0] speed_q8_4;

  modport source (output valid, output command, output setpoint_us, output speed_q8_4,
                  input ready);
  modport sink (input valid, input command, input setpoint_us, input speed_q8_4,
                output ready);
endinterface

interface spsl_res_if;
  logic                        valid;
  logic                        ready;
  logic [spsl_pkg::POS_W-1:0]  position_us;
  logic [spsl_pkg::DUTY_W-1:0] duty;
  logic                        moving;
  logic                        reached;

  modport source (output valid, output position_us, output duty, output moving,
                  output reached, input ready);
  modport sink (input valid, input position_us, input duty, input moving,
                input reached, output ready);
endinterface

[rtl/core/spsl_ramp.sv]
// Ramp state: position, goal, step size and motion flag, updated once per beat.
`timescale 1ns / 1ps

module spsl_ramp #(
  parameter int CENTER_US = 1500
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step_en,
  input  spsl_pkg::item_t     item,
  output spsl_pkg::ramp_t     res
);

  localparam int RESET_INT = (CENTER_US < 1000) ? 1000 :
                             ((CENTER_US > 2000) ? 2000 : CENTER_US);
  localparam logic [spsl_pkg::POS_W-1:0] RESET_US = spsl_pkg::POS_W'(RESET_INT);

  logic [spsl_pkg::POS_W-1:0]  position, position_next;
  logic [spsl_pkg::POS_W-1:0]  goal, goal_next;
  logic [spsl_pkg::STEP_W-1:0] step_size, step_size_next;
  logic                        in_motion, in_motion_next;
  logic                        reached, reached_next;

  logic [spsl_pkg::POS_W-1:0]  target;
  logic [14:0]                 speed_x5;
  logic [spsl_pkg::STEP_W-1:0] move_step;
  logic [spsl_pkg::STEP_W-1:0] tick_step;
  logic [spsl_pkg::POS_W-1:0]  diff;
  logic                        fits;
  logic [spsl_pkg::POS_W-1:0]  moved;

  always_comb begin
    if (item.setpoint_us < 16'(spsl_pkg::MIN_US)) begin
      target = spsl_pkg::MIN_US;
    end else if (item.setpoint_us > 16'(spsl_pkg::MAX_US)) begin
      target = spsl_pkg::MAX_US;
    end else begin
      target = item.setpoint_us[spsl_pkg::POS_W-1:0];
    end
  end

  assign speed_x5  = {3'b000, item.speed_q8_4} + {1'b0, item.speed_q8_4, 2'b00};
  assign move_step = (speed_x5[14:2] == '0) ? spsl_pkg::STEP_W'(1) : speed_x5[14:2];
  assign tick_step = (step_size == '0) ? spsl_pkg::STEP_W'(1) : step_size;

  always_comb begin
    if (goal > position) begin
      diff = goal - position;
    end else begin
      diff = position - goal;
    end
    fits = tick_step >= {2'b00, diff};
    if (fits) begin
      moved = goal;
    end else if (goal > position) begin
      moved = position + tick_step[spsl_pkg::POS_W-1:0];
    end else begin
      moved = position - tick_step[spsl_pkg::POS_W-1:0];
    end
  end

  always_comb begin
    position_next  = position;
    goal_next      = goal;
    step_size_next = step_size;
    in_motion_next = in_motion;
    reached_next   = 1'b0;
    case (item.command)
      spsl_pkg::CMD_SET: begin
        position_next  = target;
        goal_next      = target;
        in_motion_next = 1'b0;
      end
      spsl_pkg::CMD_MOVE: begin
        goal_next      = target;
        step_size_next = move_step;
        in_motion_next = 1'b1;
      end
      spsl_pkg::CMD_TICK: begin
        if (in_motion) begin
          position_next = moved;
          if (moved == goal) begin
            in_motion_next = 1'b0;
            reached_next   = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= RESET_US;
      goal      <= RESET_US;
      step_size <= '0;
      in_motion <= 1'b0;
      reached   <= 1'b0;
    end else if (step_en) begin
      position  <= position_next;
      goal      <= goal_next;
      step_size <= step_size_next;
      in_motion <= in_motion_next;
      reached   <= reached_next;
    end
  end

  assign res.position_us = position;
  assign res.moving      = in_motion;
  assign res.reached     = reached;

endmodule

[rtl/core/spsl_duty.sv]
// Position to 10-bit PWM duty (full scale 8191) over a 20 ms period, registered.
`timescale 1ns / 1ps

module spsl_duty (
  input  logic                        clk,
  input  logic                        en,
  input  logic [spsl_pkg::POS_W-1:0]  position_us,
  output logic [spsl_pkg::DUTY_W-1:0] duty
);

  logic [spsl_pkg::PROD_W-1:0]   prod;
  logic [spsl_pkg::QUOT_W-1:0]   by32;
  logic [2*spsl_pkg::QUOT_W-1:0] scaled;

  assign prod   = {position_us, 13'b0} - spsl_pkg::PROD_W'(position_us);
  assign by32   = prod[spsl_pkg::PROD_W-1:5];
  assign scaled = (2*spsl_pkg::QUOT_W)'(by32) *
                  (2*spsl_pkg::QUOT_W)'(spsl_pkg::RECIP_625);

  always_ff @(posedge clk) begin
    if (en) begin
      duty <= scaled[spsl_pkg::RECIP_SHIFT +: spsl_pkg::DUTY_W];
    end
  end

endmodule

[rtl/core/servo_pulse_slew_limiter_top.sv]
// Servo pulse slew limiter: command beats in, one result beat out per command.
//
// Channel cmd carries command (set, move, tick), setpoint_us and speed_q8_4;
// channel result carries position_us, duty, moving and reached. Both are
// valid/ready, a beat moving on a clock edge with valid and ready high.
// Every command beat yields exactly one result beat, in order.
// Result valid follows the accepting edge through three registers: the input
// register loads on the accepting edge, then the ramp state register, then the
// result register with the duty conversion, each only on an advancing edge.
// Throughput is one beat per cycle; the three registers advance together, so
// a new command is taken whenever the result register is empty or being drained.
// When the receiver holds ready low with a result waiting, the pipeline
// freezes and cmd.ready drops until the result is taken.
// Reset (rst, synchronous) empties the pipeline, puts the position and goal
// at CENTER_US clamped to 1000..2000, clears the step size and motion flag.
`timescale 1ns / 1ps

module servo_pulse_slew_limiter_top #(
  parameter int CENTER_US = 1500
) (
  input logic          clk,
  input logic          rst,
  spsl_cmd_if.sink     cmd,
  spsl_res_if.source   result
);

  logic            advance;
  logic            v1, v2, v3;
  spsl_pkg::item_t item1;
  spsl_pkg::ramp_t ramp;
  spsl_pkg::ramp_t res3;
  logic [spsl_pkg::DUTY_W-1:0] duty3;

  assign advance   = !v3 || result.ready;
  assign cmd.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= cmd.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item1.command     <= cmd.command;
      item1.setpoint_us <= cmd.setpoint_us;
      item1.speed_q8_4  <= cmd.speed_q8_4;
    end
    if (advance && v2) begin
      res3 <= ramp;
    end
  end

  spsl_ramp #(
    .CENTER_US (CENTER_US)
  ) u_ramp (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance && v1),
    .item    (item1),
    .res     (ramp)
  );

  spsl_duty u_duty (
    .clk         (clk),
    .en          (advance && v2),
    .position_us (ramp.position_us),
    .duty        (duty3)
  );

  assign result.valid       = v3;
  assign result.position_us = res3.position_us;
  assign result.moving      = res3.moving;
  assign result.reached     = res3.reached;
  assign result.duty        = duty3;

endmodule
